[design/tbt_pkg.sv]
// Shared types, constants and fixed-point helpers of the triangle tangent block.
package tbt_pkg;

	localparam int MAX_VERTICES_DEF = 1024;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TRI  = 1'b1;

	localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

	typedef struct packed {
		logic               command;
		logic [9:0]         vertex_slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic [15:0]        first_index;
		logic [15:0]        second_index;
		logic [15:0]        third_index;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] tangent_x;
		logic signed [31:0] tangent_y;
		logic signed [31:0] tangent_z;
		logic signed [31:0] bitangent_x;
		logic signed [31:0] bitangent_y;
		logic signed [31:0] bitangent_z;
		logic               skipped;
	} res_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] det;
	} div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_DIFF,
		ST_MUL,
		ST_WDIV,
		ST_OUT,
		ST_FIN
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
		if (x > 65'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -65'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [31:0] diff32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [64:0] d;
		d = {{33{a[31]}}, a} - {{33{b[31]}}, b};
		return sat32(d);
	endfunction

	function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] d;
		d = {a[63], a} - {b[63], b};
		if (d[64] != d[63])
			return d[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
		else
			return d[63:0];
	endfunction

	// floor(x / 2^16), saturated to Q16.16
	function automatic logic signed [31:0] asr_sat(input logic signed [63:0] x);
		logic signed [64:0] s;
		s = {{17{x[63]}}, x[63:16]};
		return sat32(s);
	endfunction

endpackage

[design/tbt_store.sv]
// Vertex store: one write port, one registered read port.
module tbt_store #(
	parameter int MAX_VERTICES = tbt_pkg::MAX_VERTICES_DEF,
	parameter int AW = $clog2(MAX_VERTICES)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tbt_pkg::vertex_t wdata,
	input  logic [AW-1:0]   raddr,
	output tbt_pkg::vertex_t rdata
);
	import tbt_pkg::*;

	vertex_t mem [MAX_VERTICES];
	vertex_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/tbt_mul.sv]
// Shared signed 32x32 multiplier with registered product.
module tbt_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod
);
	import tbt_pkg::*;

	logic signed [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;

endmodule

[design/tbt_div.sv]
// Reciprocal unit: 2^48 / det, one quotient bit per cycle, saturated to Q16.16.
module tbt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tbt_pkg::div_req_t  req,
	output logic signed [31:0] f,
	output logic               done
);
	import tbt_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic               neg_q;
	logic [63:0]        dmag_q;
	logic [63:0]        rem_q;
	logic [48:0]        quo_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] f_q;

	logic [64:0]        rem_sh;
	logic               ge;
	logic [64:0]        rem_nx;
	logic [48:0]        quo_nx;
	logic signed [31:0] f_nx;

	always_comb begin
		rem_sh = {rem_q, (cnt_q == 6'd48)};
		ge     = rem_sh >= {1'b0, dmag_q};
		rem_nx = ge ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
		quo_nx = {quo_q[47:0], ge};
		if (!neg_q) begin
			f_nx = (quo_nx > 49'h7fffffff) ? 32'sh7fffffff : quo_nx[31:0];
		end else begin
			f_nx = (quo_nx > 49'h80000000) ? 32'sh80000000 : (~quo_nx[31:0]) + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			if (req.det == 64'sd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end
		end else if (busy_q && cnt_q == 6'd0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q  <= req.det[63];
			dmag_q <= req.det[63] ? (64'd0 - req.det) : req.det;
			rem_q  <= 64'd0;
			quo_q  <= 49'd0;
			cnt_q  <= 6'd48;
			f_q    <= 32'sd0;
		end else if (busy_q) begin
			rem_q <= rem_nx[63:0];
			quo_q <= quo_nx;
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) begin
				f_q <= f_nx;
			end
		end
	end

	assign f    = f_q;
	assign done = done_q;

endmodule

[design/triangle_tangent_bitangent.sv]
// Top level: tangent and bitangent of a triangle from a vertex store.
//
// Request channel (cmd, cmd_valid, cmd_stall): a request is taken when
// cmd_valid is high and cmd_stall is low. A load request (command 0)
// writes one vertex into the store and gives no result.
// A triangle request (command 1) gives exactly one result on the result
// channel (res, res_valid, res_stall), taken when res_valid is high and
// res_stall is low.
// A triangle whose indices are all below min(vertex_count, MAX_VERTICES)
// goes through three store reads, fourteen passes through the shared
// 32x32 multiplier, the reciprocal 2^48/det (49 quotient bits, one per
// cycle, overlapped with the numerator products) and six output products;
// the reciprocal is the longest step. The next request can be taken in the
// same cycle that its result shows. An out-of-range triangle returns zero
// vectors with skipped set.
// cmd_stall is high while a triangle is in work. A finished result waits
// in the output register while res_stall is high; a new request can be
// taken meanwhile, and the next result waits until the register frees.
// Reset clears the sequencer, the valid flags and vertex_count; store
// contents are undefined until loaded.
// vertex_count sits at APB byte address 0; pready is always high.
module triangle_tangent_bitangent #(
	parameter int MAX_VERTICES = tbt_pkg::MAX_VERTICES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tbt_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	output tbt_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_stall,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import tbt_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	// sequencer
	state_t state_q, state_nx;
	logic [4:0] cnt_q;

	// config
	logic [10:0] vertex_count_q;
	logic [16:0] limit;

	// triangle operands
	logic [15:0]        idx_q [3];
	logic               skip_q;
	vertex_t            v_q [3];
	logic signed [31:0] e1_q [3];
	logic signed [31:0] e2_q [3];
	logic signed [31:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [31:0] nt_q [3];
	logic signed [31:0] nb_q [3];
	logic signed [31:0] vec_q [6];
	logic signed [63:0] acc_q;

	// multiplier pipeline tag: which operation the product in flight belongs to
	logic [4:0] tag_q;
	logic       tagv_q;
	logic       tag_out_q;

	// result register
	res_t rsp_q;
	logic rsp_valid_q;

	// shared units
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic               div_start_q;
	logic signed [63:0] div_det_q;
	div_req_t           div_req;
	logic signed [31:0] f;
	logic               div_done;

	// store
	logic          st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	vertex_t       st_wdata, st_rdata;
	logic [16:0]   slot_ext;
	logic [16:0]   ridx_ext;

	logic cmd_acc, cfg_wr, oor, fin_go;
	logic [3:0] pair;
	logic [1:0] comp;
	logic [3:0] tpair;
	logic [1:0] tcomp;
	logic signed [63:0] pdiff;

	assign pready = 1'b1;
	assign prdata = 32'(vertex_count_q);
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_VERTEX_COUNT);

	assign limit = (17'(vertex_count_q) < 17'(MAX_VERTICES)) ?
		17'(vertex_count_q) : 17'(MAX_VERTICES);
	assign oor = (17'(cmd.first_index) >= limit) || (17'(cmd.second_index) >= limit) ||
		(17'(cmd.third_index) >= limit);

	assign cmd_acc = cmd_valid && !cmd_stall;
	assign fin_go  = !tagv_q && (!rsp_valid_q || !res_stall);

	// store write on a load; slots past the store are dropped
	assign slot_ext = 17'(cmd.vertex_slot);
	assign st_we    = cmd_acc && (cmd.command == CMD_LOAD) && (slot_ext < 17'(MAX_VERTICES));
	assign st_waddr = slot_ext[AW-1:0];
	assign st_wdata = '{pos_x: cmd.pos_x, pos_y: cmd.pos_y, pos_z: cmd.pos_z,
		tex_u: cmd.tex_u, tex_v: cmd.tex_v};

	assign div_req = '{start: div_start_q, det: div_det_q};

	tbt_store #(
		.MAX_VERTICES(MAX_VERTICES),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	tbt_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.prod(prod)
	);

	tbt_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.f(f),
		.done(div_done)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.command == CMD_TRI) begin
					state_nx = oor ? ST_FIN : ST_RD0;
				end
			end
			ST_RD0: state_nx = ST_RD1;
			ST_RD1: state_nx = ST_RD2;
			ST_RD2: state_nx = ST_RD3;
			ST_RD3: state_nx = ST_DIFF;
			ST_DIFF: state_nx = ST_MUL;
			ST_MUL: begin
				if (cnt_q == 5'd13) state_nx = ST_WDIV;
			end
			ST_WDIV: begin
				if (div_done) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (cnt_q == 5'd5) state_nx = ST_FIN;
			end
			ST_FIN: begin
				if (fin_go) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs: stall, store read address, multiplier operands
	always_comb begin
		cmd_stall = (state_q != ST_IDLE);
		ridx_ext  = 17'(idx_q[0]);
		pair      = cnt_q[4:1];
		comp      = (pair >= 4'd4) ? 2'(pair - 4'd4) : 2'(pair - 4'd1);
		mul_a     = du1_q;
		mul_b     = dv2_q;
		case (state_q)
			ST_RD1: ridx_ext = 17'(idx_q[1]);
			ST_RD2: ridx_ext = 17'(idx_q[2]);
			ST_OUT: begin
				mul_a = f;
				mul_b = (cnt_q < 5'd3) ? nt_q[cnt_q[1:0]] : nb_q[2'(cnt_q - 5'd3)];
			end
			ST_MUL: begin
				if (pair == 4'd0) begin
					// det = du1*dv2 - du2*dv1
					mul_a = cnt_q[0] ? du2_q : du1_q;
					mul_b = cnt_q[0] ? dv1_q : dv2_q;
				end else if (pair inside {[4'd1:4'd3]}) begin
					// tangent numerator: dv2*e1 - dv1*e2
					mul_a = cnt_q[0] ? dv1_q : dv2_q;
					mul_b = cnt_q[0] ? e2_q[comp] : e1_q[comp];
				end else begin
					// bitangent numerator: du1*e2 - du2*e1
					mul_a = cnt_q[0] ? du2_q : du1_q;
					mul_b = cnt_q[0] ? e1_q[comp] : e2_q[comp];
				end
			end
			default: ;
		endcase
		st_raddr = ridx_ext[AW-1:0];
	end

	// consume side of the multiplier
	always_comb begin
		tpair = tag_q[4:1];
		tcomp = (tpair >= 4'd4) ? 2'(tpair - 4'd4) : 2'(tpair - 4'd1);
		pdiff = sat_sub64(acc_q, prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= 5'd0;
			vertex_count_q <= 11'd0;
			tagv_q         <= 1'b0;
			rsp_valid_q    <= 1'b0;
			div_start_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr) vertex_count_q <= pwdata[10:0];
			if (state_q != state_nx) cnt_q <= 5'd0;
			else if (state_q == ST_MUL || state_q == ST_OUT) cnt_q <= cnt_q + 5'd1;
			tagv_q <= (state_q == ST_MUL) || (state_q == ST_OUT);
			div_start_q <= tagv_q && !tag_out_q && (tag_q == 5'd1);
			if (state_q == ST_FIN && fin_go) rsp_valid_q <= 1'b1;
			else if (res_stall == 1'b0) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		tag_q     <= cnt_q;
		tag_out_q <= (state_q == ST_OUT);
		if (state_q == ST_IDLE && cmd_acc) begin
			idx_q[0] <= cmd.first_index;
			idx_q[1] <= cmd.second_index;
			idx_q[2] <= cmd.third_index;
			skip_q   <= oor;
		end
		if (state_q == ST_RD1) v_q[0] <= st_rdata;
		if (state_q == ST_RD2) v_q[1] <= st_rdata;
		if (state_q == ST_RD3) v_q[2] <= st_rdata;
		if (state_q == ST_DIFF) begin
			e1_q[0] <= diff32(v_q[1].pos_x, v_q[0].pos_x);
			e1_q[1] <= diff32(v_q[1].pos_y, v_q[0].pos_y);
			e1_q[2] <= diff32(v_q[1].pos_z, v_q[0].pos_z);
			e2_q[0] <= diff32(v_q[2].pos_x, v_q[0].pos_x);
			e2_q[1] <= diff32(v_q[2].pos_y, v_q[0].pos_y);
			e2_q[2] <= diff32(v_q[2].pos_z, v_q[0].pos_z);
			du1_q   <= diff32(v_q[1].tex_u, v_q[0].tex_u);
			dv1_q   <= diff32(v_q[1].tex_v, v_q[0].tex_v);
			du2_q   <= diff32(v_q[2].tex_u, v_q[0].tex_u);
			dv2_q   <= diff32(v_q[2].tex_v, v_q[0].tex_v);
		end
		if (tagv_q) begin
			if (tag_out_q) begin
				vec_q[tag_q[2:0]] <= asr_sat(prod);
			end else if (!tag_q[0]) begin
				acc_q <= prod;
			end else if (tpair == 4'd0) begin
				div_det_q <= pdiff;
			end else if (tpair < 4'd4) begin
				nt_q[tcomp] <= asr_sat(pdiff);
			end else begin
				nb_q[tcomp] <= asr_sat(pdiff);
			end
		end
		if (state_q == ST_FIN && fin_go) begin
			if (skip_q) begin
				rsp_q <= '{tangent_x: 32'sd0, tangent_y: 32'sd0, tangent_z: 32'sd0,
					bitangent_x: 32'sd0, bitangent_y: 32'sd0, bitangent_z: 32'sd0,
					skipped: 1'b1};
			end else begin
				rsp_q <= '{tangent_x: vec_q[0], tangent_y: vec_q[1], tangent_z: vec_q[2],
					bitangent_x: vec_q[3], bitangent_y: vec_q[4], bitangent_z: vec_q[5],
					skipped: 1'b0};
			end
		end
	end

	assign res       = rsp_q;
	assign res_valid = rsp_valid_q;

	// output products never start before the reciprocal is ready
	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> div_done)
		else $error("output products started before reciprocal finished");

	// a new result only comes out of the finish step
	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finish step");

	// a skipped triangle carries zero vectors
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.skipped) |-> (res.tangent_x == 32'sd0 && res.tangent_y == 32'sd0 &&
		res.tangent_z == 32'sd0 && res.bitangent_x == 32'sd0 &&
		res.bitangent_y == 32'sd0 && res.bitangent_z == 32'sd0))
		else $error("skipped result with nonzero vectors");

	// the multiplier pipeline is empty when a result is handed over
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && state_nx == ST_IDLE) |-> !tagv_q)
		else $error("result loaded with a product in flight");

endmodule
